// ===== rtl/grid_height_triangle_interp_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on i_clk; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef GRID_HEIGHT_TRIANGLE_INTERP_ASSERT_SVH
`define GRID_HEIGHT_TRIANGLE_INTERP_ASSERT_SVH
`ifndef SYNTHESIS
// check outside reset
`define GHTI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check at every edge, reset included
`define GHTI_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GHTI_ASSERT(lbl, prop, msg)
`define GHTI_ASSERT_ALL(lbl, prop, msg)
`endif
`endif

// ===== rtl/ghti_pkg.sv =====
// ----------------------------------------------------------------------------
// ghti_pkg
// Shared types and constants of the grid height triangle interpolator.
// ----------------------------------------------------------------------------
package ghti_pkg;

    localparam int POS_W  = 32;
    localparam int HGT_W  = 32;
    localparam int FRAC_W = 16;
    localparam int HALF_W = 31;
    localparam int IDX_W  = 7;

    typedef logic t_opcode;
    localparam t_opcode OP_WRITE = 1'b0;
    localparam t_opcode OP_QUERY = 1'b1;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ORIGIN_X  = 2'd0;
    localparam t_cfg_idx CFG_ORIGIN_Z  = 2'd1;
    localparam t_cfg_idx CFG_HALF_SIZE = 2'd2;
    localparam t_cfg_idx CFG_INV_CELL  = 2'd3;

    localparam logic [HALF_W-1:0] HALF_SIZE_RST = 31'd65536;
    localparam logic [POS_W-1:0]  INV_CELL_RST  = 32'd65536;

    // pipeline stage positions
    localparam int ST_ADD     = 0;
    localparam int ST_MUL     = 1;
    localparam int ST_CELL    = 2;
    localparam int ST_READ    = 3;
    localparam int ST_DIFF    = 4;
    localparam int ST_PROD    = 5;
    localparam int ST_OUT     = 6;
    localparam int NUM_STAGES = 7;

    // per-stage load enables
    typedef struct packed {
        logic add;
        logic mul;
        logic split;
        logic rd;
        logic diff;
        logic prod;
        logic out;
    } t_pipe_en;

endpackage

// ===== rtl/ghti_ifs.sv =====
// ----------------------------------------------------------------------------
// ghti channel interfaces
// Valid/ready channels for input items and for results.
// ----------------------------------------------------------------------------
interface ghti_in_if
    import ghti_pkg::*;
;
    logic                     valid;
    logic                     ready;
    t_opcode                  opcode;
    logic signed [POS_W-1:0]  x_pos;
    logic signed [POS_W-1:0]  z_pos;
    logic [IDX_W-1:0]         column;
    logic [IDX_W-1:0]         row;
    logic signed [HGT_W-1:0]  sample;

    modport source (output valid, opcode, x_pos, z_pos, column, row, sample, input ready);
    modport sink   (input valid, opcode, x_pos, z_pos, column, row, sample, output ready);
endinterface

interface ghti_out_if
    import ghti_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [HGT_W-1:0]  height;
    logic                     outside;

    modport source (output valid, height, outside, input ready);
    modport sink   (input valid, height, outside, output ready);
endinterface

// ===== rtl/ghti_map.sv =====
// ----------------------------------------------------------------------------
// ghti_map
// One axis: offset, scale by the reciprocal cell size, split cell / fraction.
// ----------------------------------------------------------------------------
module ghti_map
    import ghti_pkg::*;
#(
    parameter int GRID_POINTS = 128,
    localparam int CW = $clog2(GRID_POINTS)
) (
    input  logic                     i_clk,
    input  t_pipe_en                 i_en,
    input  logic signed [POS_W-1:0]  i_pos,
    input  logic signed [POS_W-1:0]  i_org,
    input  logic [HALF_W-1:0]        i_half,
    input  logic [POS_W-1:0]         i_inv,
    output logic [CW-1:0]            o_cell,
    output logic [FRAC_W-1:0]        o_frac,
    output logic                     o_off
);

    logic signed [POS_W+1:0] r_t;
    logic                    r_neg;
    logic                    r_hi;
    logic [2*POS_W-1:16]     r_plo;
    logic [2*POS_W-1:0]      w_plo;
    logic [POS_W:0]          w_idx;
    logic                    w_off;
    logic [CW-1:0]           r_cell;
    logic [FRAC_W-1:0]       r_frac;
    logic                    r_off;

    assign w_plo = 64'(r_t[POS_W-1:0]) * 64'(i_inv);
    assign w_idx = {1'b0, r_plo[2*POS_W-1:POS_W]} + (r_hi ? {1'b0, i_inv} : 33'd0);
    assign w_off = r_neg ? (i_inv != '0) : (w_idx >= 33'(GRID_POINTS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en.add) begin
            r_t <= i_pos - i_org + $signed({1'b0, i_half});
        end
        if (i_en.mul) begin
            r_neg <= r_t[POS_W+1];
            r_hi  <= r_t[POS_W];
            r_plo <= w_plo[2*POS_W-1:16];
        end
        if (i_en.split) begin
            r_cell <= w_off ? '0 : CW'(w_idx);
            r_frac <= r_plo[POS_W-1:16];
            r_off  <= w_off;
        end
    end

    assign o_cell = r_cell;
    assign o_frac = r_frac;
    assign o_off  = r_off;

endmodule

// ===== rtl/ghti_store.sv =====
// ----------------------------------------------------------------------------
// ghti_store
// Height samples in four banks by row and column parity; four corners a cycle.
// ----------------------------------------------------------------------------
module ghti_store
    import ghti_pkg::*;
#(
    parameter int GRID_POINTS = 128,
    localparam int CW = $clog2(GRID_POINTS)
) (
    input  logic                     i_clk,
    input  t_pipe_en                 i_en,
    input  logic                     i_wr,
    input  logic [CW-1:0]            i_wr_col,
    input  logic [CW-1:0]            i_wr_row,
    input  logic signed [HGT_W-1:0]  i_wr_data,
    input  logic [CW-1:0]            i_cx,
    input  logic [CW-1:0]            i_cz,
    output logic signed [HGT_W-1:0]  o_h00,
    output logic signed [HGT_W-1:0]  o_h10,
    output logic signed [HGT_W-1:0]  o_h01,
    output logic signed [HGT_W-1:0]  o_h11
);

    localparam int HALF       = (GRID_POINTS + 1) / 2;
    localparam int BANK_DEPTH = HALF * HALF;
    localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    logic signed [HGT_W-1:0] w_q00, w_q01, w_q10, w_q11;
    logic                    r_px;
    logic                    r_pz;
    logic [AW-1:0]           w_wr_addr;

    assign w_wr_addr = AW'((int'(i_wr_row) >> 1) * HALF + (int'(i_wr_col) >> 1));

    for (genvar pr = 0; pr < 2; pr++) begin : g_row
        for (genvar pc = 0; pc < 2; pc++) begin : g_col
            logic signed [HGT_W-1:0] r_mem [BANK_DEPTH];
            logic signed [HGT_W-1:0] r_rd;
            logic [CW-1:0]           w_r;
            logic [CW-1:0]           w_c;
            logic [AW-1:0]           w_addr;
            logic                    w_we;

            assign w_r    = (i_cz[0] == 1'(pr)) ? i_cz : i_cz + 1'b1;
            assign w_c    = (i_cx[0] == 1'(pc)) ? i_cx : i_cx + 1'b1;
            assign w_addr = AW'((int'(w_r) >> 1) * HALF + (int'(w_c) >> 1));
            assign w_we   = i_wr && (i_wr_row[0] == 1'(pr)) && (i_wr_col[0] == 1'(pc));

            always_ff @(posedge i_clk) begin
                if (w_we) begin
                    r_mem[w_wr_addr] <= i_wr_data;
                end
                if (i_en.rd) begin
                    r_rd <= r_mem[w_addr];
                end
            end
        end
    end

    assign w_q00 = g_row[0].g_col[0].r_rd;
    assign w_q01 = g_row[0].g_col[1].r_rd;
    assign w_q10 = g_row[1].g_col[0].r_rd;
    assign w_q11 = g_row[1].g_col[1].r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            r_px <= i_cx[0];
            r_pz <= i_cz[0];
        end
    end

    // unscramble banks into corners
    always_comb begin
        case ({r_pz, r_px})
            2'b00: begin
                o_h00 = w_q00; o_h10 = w_q01; o_h01 = w_q10; o_h11 = w_q11;
            end
            2'b01: begin
                o_h00 = w_q01; o_h10 = w_q00; o_h01 = w_q11; o_h11 = w_q10;
            end
            2'b10: begin
                o_h00 = w_q10; o_h10 = w_q11; o_h01 = w_q00; o_h11 = w_q01;
            end
            default: begin
                o_h00 = w_q11; o_h10 = w_q10; o_h01 = w_q01; o_h11 = w_q00;
            end
        endcase
    end

endmodule

// ===== rtl/ghti_blend.sv =====
// ----------------------------------------------------------------------------
// ghti_blend
// Triangle select, edge differences, weighting, rounding and saturation.
// ----------------------------------------------------------------------------
module ghti_blend
    import ghti_pkg::*;
(
    input  logic                     i_clk,
    input  t_pipe_en                 i_en,
    input  logic [FRAC_W-1:0]        i_fx,
    input  logic [FRAC_W-1:0]        i_fz,
    input  logic                     i_off,
    input  logic signed [HGT_W-1:0]  i_h00,
    input  logic signed [HGT_W-1:0]  i_h10,
    input  logic signed [HGT_W-1:0]  i_h01,
    input  logic signed [HGT_W-1:0]  i_h11,
    output logic signed [HGT_W-1:0]  o_height,
    output logic                     o_outside
);

    localparam int DW = HGT_W + 1;
    localparam int PW = DW + FRAC_W + 1;
    localparam int AW = PW + 2;
    localparam int QW = AW - FRAC_W;
    localparam logic signed [QW-1:0] SAT_MAX = QW'(64'sd2147483647);
    localparam logic signed [QW-1:0] SAT_MIN = QW'(-64'sd2147483648);

    // read stage
    logic [FRAC_W-1:0]       r_fx_d, r_fz_d;
    logic                    r_off_d;
    logic                    w_lower;
    logic signed [DW-1:0]    w_da, w_db;
    // diff stage
    logic signed [DW-1:0]    r_da, r_db;
    logic signed [HGT_W-1:0] r_h00_e;
    logic [FRAC_W-1:0]       r_fx_e, r_fz_e;
    logic                    r_off_e;
    logic signed [FRAC_W:0]  w_fxs, w_fzs;
    logic signed [PW-1:0]    w_p1, w_p2;
    // product stage
    logic signed [PW-1:0]    r_p1, r_p2;
    logic signed [HGT_W-1:0] r_h00_f;
    logic                    r_off_f;
    logic signed [AW-1:0]    w_acc;
    logic signed [QW-1:0]    w_q;
    logic signed [HGT_W-1:0] w_sat;
    // output
    logic signed [HGT_W-1:0] r_height;
    logic                    r_outside;

    assign w_lower = (r_fx_d <= r_fz_d);
    assign w_da    = w_lower ? (i_h11 - i_h01) : (i_h10 - i_h00);
    assign w_db    = w_lower ? (i_h01 - i_h00) : (i_h11 - i_h10);

    assign w_fxs = $signed({1'b0, r_fx_e});
    assign w_fzs = $signed({1'b0, r_fz_e});
    assign w_p1  = w_fxs * r_da;
    assign w_p2  = w_fzs * r_db;

    assign w_acc = (AW'(r_h00_f) <<< FRAC_W) + AW'(r_p1) + AW'(r_p2)
                 + AW'(32'sd32768);
    assign w_q   = w_acc[AW-1:FRAC_W];

    always_comb begin
        if (w_q > SAT_MAX) begin
            w_sat = HGT_W'(SAT_MAX);
        end else if (w_q < SAT_MIN) begin
            w_sat = HGT_W'(SAT_MIN);
        end else begin
            w_sat = w_q[HGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.rd) begin
            r_fx_d  <= i_fx;
            r_fz_d  <= i_fz;
            r_off_d <= i_off;
        end
        if (i_en.diff) begin
            r_da    <= w_da;
            r_db    <= w_db;
            r_h00_e <= i_h00;
            r_fx_e  <= r_fx_d;
            r_fz_e  <= r_fz_d;
            r_off_e <= r_off_d;
        end
        if (i_en.prod) begin
            r_p1    <= w_p1;
            r_p2    <= w_p2;
            r_h00_f <= r_h00_e;
            r_off_f <= r_off_e;
        end
        if (i_en.out) begin
            r_height  <= r_off_f ? '0 : w_sat;
            r_outside <= r_off_f;
        end
    end

    assign o_height  = r_height;
    assign o_outside = r_outside;

endmodule

// ===== rtl/grid_height_triangle_interp.sv =====
// ----------------------------------------------------------------------------
// grid_height_triangle_interp
// Heightmap store with pipelined triangle interpolation of query points.
// ----------------------------------------------------------------------------
// Items enter on i_item; opcode selects a sample write or a point query.
// A write stores sample at (column, row); writes off the grid are dropped.
// A query returns one transfer on o_result: the height over the lower or
// upper triangle of the cell under (x_pos, z_pos), or outside set and zero
// height when the cell lies off the grid. Writes give no result.
// Configuration goes through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while idle, which the block does not enforce. Seven
// register stages: offset, scale multiply, cell split, bank read, edge
// differences, weight multiply, round and saturate. The block takes one
// item per cycle while o_result accepts; the four corner reads hit four
// parity banks in the same cycle, with no bank conflict. A write lands in
// the store as it leaves the cell stage, in item order with queries.
// Reset clears the pipeline and resets the configuration, not the store.
// When o_result stalls, stages fill up and i_item.ready drops once the
// pipeline is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "grid_height_triangle_interp_assert.svh"

module grid_height_triangle_interp
    import ghti_pkg::*;
#(
    parameter int GRID_POINTS = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ghti_in_if.sink           i_item,
    ghti_out_if.source        o_result,
    input  logic              i_cfg_we,
    input  t_cfg_idx          i_cfg_index,
    input  logic [POS_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(GRID_POINTS);

    logic signed [POS_W-1:0]  r_origin_x;
    logic signed [POS_W-1:0]  r_origin_z;
    logic [HALF_W-1:0]        r_half_size;
    logic [POS_W-1:0]         r_inv_cell;

    logic [NUM_STAGES-1:0]    r_valid;
    logic [NUM_STAGES-1:0]    n_valid;
    logic [NUM_STAGES-1:0]    w_load;
    logic [NUM_STAGES-1:0]    w_move;
    t_pipe_en                 w_en;

    t_opcode                  r_op_a, r_op_b, r_op_c;
    logic                     r_wok_a, r_wok_b, r_wok_c;
    logic [CW-1:0]            r_col_a, r_col_b, r_col_c;
    logic [CW-1:0]            r_row_a, r_row_b, r_row_c;
    logic signed [HGT_W-1:0]  r_smp_a, r_smp_b, r_smp_c;
    logic                     w_wr_c;
    logic                     w_wr_fire;

    logic [CW-1:0]            w_cx, w_cz;
    logic [FRAC_W-1:0]        w_fx, w_fz;
    logic                     w_off_x, w_off_z;
    logic signed [HGT_W-1:0]  w_h00, w_h10, w_h01, w_h11;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x  <= '0;
            r_origin_z  <= '0;
            r_half_size <= HALF_SIZE_RST;
            r_inv_cell  <= INV_CELL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X:  r_origin_x  <= i_cfg_data;
                CFG_ORIGIN_Z:  r_origin_z  <= i_cfg_data;
                CFG_HALF_SIZE: r_half_size <= i_cfg_data[HALF_W-1:0];
                CFG_INV_CELL:  r_inv_cell  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign w_wr_c    = (r_op_c == OP_WRITE);
    assign w_wr_fire = r_valid[ST_CELL] && w_wr_c && r_wok_c;

    always_comb begin
        w_move[ST_OUT]  = r_valid[ST_OUT] & o_result.ready;
        w_load[ST_OUT]  = ~r_valid[ST_OUT] | w_move[ST_OUT];
        w_move[ST_PROD] = r_valid[ST_PROD] & w_load[ST_OUT];
        w_load[ST_PROD] = ~r_valid[ST_PROD] | w_move[ST_PROD];
        w_move[ST_DIFF] = r_valid[ST_DIFF] & w_load[ST_PROD];
        w_load[ST_DIFF] = ~r_valid[ST_DIFF] | w_move[ST_DIFF];
        w_move[ST_READ] = r_valid[ST_READ] & w_load[ST_DIFF];
        w_load[ST_READ] = ~r_valid[ST_READ] | w_move[ST_READ];
        // a write leaves at the cell stage
        w_move[ST_CELL] = r_valid[ST_CELL] & (w_wr_c | w_load[ST_READ]);
        w_load[ST_CELL] = ~r_valid[ST_CELL] | w_move[ST_CELL];
        w_move[ST_MUL]  = r_valid[ST_MUL] & w_load[ST_CELL];
        w_load[ST_MUL]  = ~r_valid[ST_MUL] | w_move[ST_MUL];
        w_move[ST_ADD]  = r_valid[ST_ADD] & w_load[ST_MUL];
        w_load[ST_ADD]  = ~r_valid[ST_ADD] | w_move[ST_ADD];
    end

    always_comb begin
        n_valid = r_valid;
        if (w_load[ST_ADD])  n_valid[ST_ADD]  = i_item.valid;
        if (w_load[ST_MUL])  n_valid[ST_MUL]  = r_valid[ST_ADD];
        if (w_load[ST_CELL]) n_valid[ST_CELL] = r_valid[ST_MUL];
        if (w_load[ST_READ]) n_valid[ST_READ] = r_valid[ST_CELL] & ~w_wr_c;
        if (w_load[ST_DIFF]) n_valid[ST_DIFF] = r_valid[ST_READ];
        if (w_load[ST_PROD]) n_valid[ST_PROD] = r_valid[ST_DIFF];
        if (w_load[ST_OUT])  n_valid[ST_OUT]  = r_valid[ST_PROD];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign w_en.add   = w_load[ST_ADD];
    assign w_en.mul   = w_load[ST_MUL];
    assign w_en.split = w_load[ST_CELL];
    assign w_en.rd    = w_load[ST_READ];
    assign w_en.diff  = w_load[ST_DIFF];
    assign w_en.prod  = w_load[ST_PROD];
    assign w_en.out   = w_load[ST_OUT];

    assign i_item.ready   = w_load[ST_ADD];
    assign o_result.valid = r_valid[ST_OUT];

    // write item path up to the store
    always_ff @(posedge i_clk) begin
        if (w_en.add) begin
            r_op_a  <= i_item.opcode;
            r_wok_a <= (32'(i_item.column) < GRID_POINTS) && (32'(i_item.row) < GRID_POINTS);
            r_col_a <= CW'(i_item.column);
            r_row_a <= CW'(i_item.row);
            r_smp_a <= i_item.sample;
        end
        if (w_en.mul) begin
            r_op_b  <= r_op_a;
            r_wok_b <= r_wok_a;
            r_col_b <= r_col_a;
            r_row_b <= r_row_a;
            r_smp_b <= r_smp_a;
        end
        if (w_en.split) begin
            r_op_c  <= r_op_b;
            r_wok_c <= r_wok_b;
            r_col_c <= r_col_b;
            r_row_c <= r_row_b;
            r_smp_c <= r_smp_b;
        end
    end

    ghti_map #(.GRID_POINTS(GRID_POINTS)) u_map_x (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_pos  (i_item.x_pos),
        .i_org  (r_origin_x),
        .i_half (r_half_size),
        .i_inv  (r_inv_cell),
        .o_cell (w_cx),
        .o_frac (w_fx),
        .o_off  (w_off_x)
    );

    ghti_map #(.GRID_POINTS(GRID_POINTS)) u_map_z (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_pos  (i_item.z_pos),
        .i_org  (r_origin_z),
        .i_half (r_half_size),
        .i_inv  (r_inv_cell),
        .o_cell (w_cz),
        .o_frac (w_fz),
        .o_off  (w_off_z)
    );

    ghti_store #(.GRID_POINTS(GRID_POINTS)) u_store (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_wr      (w_wr_fire),
        .i_wr_col  (r_col_c),
        .i_wr_row  (r_row_c),
        .i_wr_data (r_smp_c),
        .i_cx      (w_cx),
        .i_cz      (w_cz),
        .o_h00     (w_h00),
        .o_h10     (w_h10),
        .o_h01     (w_h01),
        .o_h11     (w_h11)
    );

    ghti_blend u_blend (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_fx      (w_fx),
        .i_fz      (w_fz),
        .i_off     (w_off_x | w_off_z),
        .i_h00     (w_h00),
        .i_h10     (w_h10),
        .i_h01     (w_h01),
        .i_h11     (w_h11),
        .o_height  (o_result.height),
        .o_outside (o_result.outside)
    );

    `GHTI_ASSERT(a_query_reaches_read, (r_valid[ST_CELL] && !w_wr_c && w_move[ST_CELL]) |=> r_valid[ST_READ], "query dropped between cell and read stages")
    `GHTI_ASSERT(a_result_held, (r_valid[ST_OUT] && !o_result.ready) |=> r_valid[ST_OUT], "stalled result lost")
    `GHTI_ASSERT(a_outside_zero, (r_valid[ST_OUT] && o_result.outside) |-> (o_result.height == '0), "outside result with nonzero height")
    `GHTI_ASSERT_ALL(a_reset_clears, !i_rst_n |=> (r_valid == '0), "pipeline not empty after reset")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for grid_height_triangle_interp. Sample writes and point
// queries go in over the item channel; each query result is checked against an
// in-bench model of the height grid and its triangle interpolation, under
// default, extreme and random register settings, with random stalls on both
// channels, a long result hold-off and a final stall-free stretch.
// ----------------------------------------------------------------------------
module testbench;
    import ghti_pkg::*;

    localparam int GRID_POINTS  = 128;
    localparam int STORE_DEPTH  = GRID_POINTS * GRID_POINTS;
    localparam int PIPE_LATENCY = 7;
    localparam int RANDOM_ITEMS = 300;
    localparam logic signed [POS_W-1:0] ONE_Q = 32'sh0001_0000;

    typedef struct {
        t_opcode                 opcode;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] z_pos;
        logic [IDX_W-1:0]        column;
        logic [IDX_W-1:0]        row;
        logic signed [HGT_W-1:0] sample;
    } t_grid_item;

    typedef struct {
        logic signed [HGT_W-1:0] height;
        logic                    outside;
    } t_height_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    t_cfg_idx         i_cfg_index;
    logic [POS_W-1:0] i_cfg_data;

    ghti_in_if  item_if ();
    ghti_out_if result_if ();

    grid_height_triangle_interp #(
        .GRID_POINTS(GRID_POINTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_result   (result_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    logic signed [HGT_W-1:0] height_mem [STORE_DEPTH];
    bit                      sample_valid [STORE_DEPTH];
    logic signed [POS_W-1:0] org_x;
    logic signed [POS_W-1:0] org_z;
    logic [HALF_W-1:0]       half_extent;
    logic [POS_W-1:0]        inv_cell_w;

    t_height_result pending_heights [$];
    t_height_result head_result;

    int n_errors;
    int n_items;
    int n_writes;
    int n_checked;
    int n_outside;
    int n_cfg;
    bit src_idle_en;
    bit snk_idle_en;
    int hold_off_req;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int store_addr(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        return int'(row) * GRID_POINTS + int'(col);
    endfunction

    function automatic bit grid_locate(input logic signed [POS_W-1:0] pos,
                                       input logic signed [POS_W-1:0] org,
                                       output logic [IDX_W-1:0] idx,
                                       output logic [FRAC_W-1:0] frac);
        longint          t;
        longint unsigned lo, hi, ic, lo_prod, whole;
        idx  = '0;
        frac = '0;
        t = longint'(pos) - longint'(org) + longint'({1'b0, half_extent});
        if (t < 0) begin
            return (inv_cell_w == '0);
        end
        lo      = t[31:0];
        hi      = t[63:32];
        ic      = inv_cell_w;
        lo_prod = lo * ic;
        whole   = (lo_prod >> 32) + hi * ic;
        if (whole >= GRID_POINTS - 1) begin
            return 1'b0;
        end
        idx  = whole[IDX_W-1:0];
        frac = lo_prod[31:16];
        return 1'b1;
    endfunction

    function automatic t_height_result interp_height(input t_grid_item it);
        logic [IDX_W-1:0]  cx, cz;
        logic [FRAC_W-1:0] fx, fz;
        longint            h00, h10, h01, h11, acc, r;
        bit                in_x, in_z;
        t_height_result    res;
        res.height  = '0;
        res.outside = 1'b1;
        in_x = grid_locate(it.x_pos, org_x, cx, fx);
        in_z = grid_locate(it.z_pos, org_z, cz, fz);
        if (!(in_x && in_z)) begin
            return res;
        end
        h00 = height_mem[store_addr(cx, cz)];
        h10 = height_mem[store_addr(cx + 1, cz)];
        h01 = height_mem[store_addr(cx, cz + 1)];
        h11 = height_mem[store_addr(cx + 1, cz + 1)];
        acc = h00 * 65536;
        if (fx <= fz) begin
            acc += longint'(fx) * (h11 - h01) + longint'(fz) * (h01 - h00);
        end else begin
            acc += longint'(fx) * (h10 - h00) + longint'(fz) * (h11 - h10);
        end
        r = (acc + 32768) >>> 16;
        if (r > longint'(32'sh7FFF_FFFF)) r = longint'(32'sh7FFF_FFFF);
        if (r < longint'(32'sh8000_0000)) r = longint'(32'sh8000_0000);
        res.height  = r[HGT_W-1:0];
        res.outside = 1'b0;
        return res;
    endfunction

    function automatic t_grid_item random_item();
        t_grid_item it;
        it.opcode = t_opcode'($urandom_range(0, 1));
        it.x_pos  = $urandom;
        it.z_pos  = $urandom;
        it.column = $urandom_range(0, GRID_POINTS - 1);
        it.row    = $urandom_range(0, GRID_POINTS - 1);
        it.sample = $urandom;
        return it;
    endfunction

    // mostly lands on the grid under the current setting, sometimes just below it
    function automatic logic signed [POS_W-1:0] pick_coord(input logic signed [POS_W-1:0] org);
        longint unsigned span;
        longint          base, d, pos64;
        base = longint'(org) - longint'({1'b0, half_extent});
        if (inv_cell_w == '0) begin
            span = 64'h1_0000_0000;
        end else begin
            span = (64'd128 << 32) / inv_cell_w;
        end
        if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: d = -longint'($urandom_range(1, 262144));
            default: d = longint'(({32'b0, $urandom} * span) >> 32);
        endcase
        pos64 = base + d;
        return pos64[POS_W-1:0];
    endfunction

    task automatic send_item(input t_grid_item it);
        @(negedge i_clk);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        item_if.valid  <= 1'b1;
        item_if.opcode <= it.opcode;
        item_if.x_pos  <= it.x_pos;
        item_if.z_pos  <= it.z_pos;
        item_if.column <= it.column;
        item_if.row    <= it.row;
        item_if.sample <= it.sample;
        do @(posedge i_clk); while (!item_if.ready);
        n_items++;
        if (it.opcode == OP_WRITE) begin
            height_mem[store_addr(it.column, it.row)]   = it.sample;
            sample_valid[store_addr(it.column, it.row)] = 1'b1;
            n_writes++;
        end else begin
            pending_heights.push_back(interp_height(it));
        end
    endtask

    task automatic write_sample(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row,
                                input logic signed [HGT_W-1:0] value);
        t_grid_item w;
        w        = random_item();
        w.opcode = OP_WRITE;
        w.column = col;
        w.row    = row;
        w.sample = value;
        send_item(w);
    endtask

    // fill any unwritten corner of the target cell before the query itself
    task automatic run_query(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] z);
        t_grid_item        q;
        logic [IDX_W-1:0]  cx, cz;
        logic [FRAC_W-1:0] fx, fz;
        bit                in_x, in_z;
        q        = random_item();
        q.opcode = OP_QUERY;
        q.x_pos  = x;
        q.z_pos  = z;
        in_x = grid_locate(x, org_x, cx, fx);
        in_z = grid_locate(z, org_z, cz, fz);
        if (in_x && in_z) begin
            for (int k = 0; k < 4; k++) begin
                if (!sample_valid[store_addr(cx + k[0], cz + k[1])]) begin
                    write_sample(cx + k[0], cz + k[1], $urandom);
                end
            end
        end
        send_item(q);
    endtask

    task automatic random_op();
        t_grid_item w;
        if ($urandom_range(0, 3) == 0) begin
            w        = random_item();
            w.opcode = OP_WRITE;
            send_item(w);
        end else begin
            run_query(pick_coord(org_x), pick_coord(org_z));
        end
    endtask

    task automatic wait_drain();
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        while (pending_heights.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [POS_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ORIGIN_X:  org_x = value;
            CFG_ORIGIN_Z:  org_z = value;
            CFG_HALF_SIZE: half_extent = value[HALF_W-1:0];
            CFG_INV_CELL:  inv_cell_w = value;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic apply_config(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oz,
                                input logic [POS_W-1:0] hs, input logic [POS_W-1:0] ic);
        wait_drain();
        set_reg(CFG_ORIGIN_X, ox);
        set_reg(CFG_ORIGIN_Z, oz);
        set_reg(CFG_HALF_SIZE, hs);
        set_reg(CFG_INV_CELL, ic);
    endtask

    task automatic apply_random_config();
        logic [POS_W-1:0] ic;
        case ($urandom_range(0, 7))
            0: ic = 32'h0001_0000;
            1: ic = 32'h0002_0000;
            2: ic = 32'h0000_8000;
            3: ic = 32'h0000_0100;
            4: ic = 32'hFFFF_FFFF;
            5: ic = '0;
            default: ic = $urandom;
        endcase
        if ($urandom_range(0, 9) < 7) begin
            apply_config($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                         $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                         $urandom_range(0, 32'h0040_0000), ic);
        end else begin
            apply_config($urandom, $urandom, $urandom, ic);
        end
    endtask

    // default mapping: one unit cells, grid starting at -1.0
    task automatic test_default_mapping();
        run_query(-ONE_Q, -ONE_Q);
        run_query(-ONE_Q - 1, 32'sh0000_4000);
        run_query(32'sh007E_0000, 32'sh0001_0000);
        run_query(32'sh007D_FFFF, 32'sh007D_FFFF);
        run_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        run_query(32'sh8000_0000, 32'sh8000_0000);
        run_query(-ONE_Q + 32'sh0000_C000, -ONE_Q + 32'sh0000_4000);
        run_query(-ONE_Q + 32'sh0000_4000, -ONE_Q + 32'sh0000_C000);
        run_query(-ONE_Q + 32'sh0000_8000, -ONE_Q + 32'sh0000_8000);
    endtask

    task automatic test_extreme_samples();
        write_sample(3, 3, 32'sh7FFF_FFFF);
        write_sample(4, 3, 32'sh8000_0000);
        write_sample(3, 4, 32'sh8000_0000);
        write_sample(4, 4, 32'sh7FFF_FFFF);
        run_query(32'sh0002_FFFF, 32'sh0002_0000);
        run_query(32'sh0002_0001, 32'sh0002_FFFF);
        run_query(32'sh0002_FFFF, 32'sh0002_FFFF);
        run_query(32'sh0002_8000, 32'sh0002_7FFF);
        write_sample(127, 127, 32'sh8000_0000);
        run_query(32'sh007D_FFFF, 32'sh007D_C000);
    endtask

    task automatic test_config_extremes();
        apply_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        repeat (20) random_op();
        apply_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        repeat (20) random_op();
        apply_config($urandom, $urandom, $urandom, 32'h0000_0000);
        repeat (20) random_op();
        apply_config(32'hFFFA_8000, 32'h0003_4000, 32'h0040_0000, 32'h0002_0000);
        repeat (20) random_op();
    endtask

    task automatic test_random_mix();
        int start_count;
        start_count = n_items;
        while (n_items - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) apply_random_config();
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(40, 90)) random_op();
        end
    endtask

    task automatic test_backpressure();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        apply_config(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        hold_off_req = 80;
        repeat (40) run_query(pick_coord(org_x), pick_coord(org_z));
        wait_drain();
    endtask

    task automatic test_streaming();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        apply_random_config();
        repeat (60) random_op();
    endtask

    always begin
        @(negedge i_clk);
        if (hold_off_req > 0) begin
            result_if.ready <= 1'b0;
            repeat (hold_off_req) @(negedge i_clk);
            hold_off_req = 0;
            result_if.ready <= 1'b1;
        end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
            result_if.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
            result_if.ready <= 1'b1;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_heights.size() == 0) begin
                n_errors++;
                $display("%0t ns: unexpected result, expected none, actual height %0d outside %0b",
                         $time, result_if.height, result_if.outside);
            end else begin
                head_result = pending_heights.pop_front();
                n_checked++;
                if (head_result.outside) n_outside++;
                if (result_if.outside !== head_result.outside) begin
                    n_errors++;
                    $display("%0t ns: outside mismatch, expected %0b actual %0b",
                             $time, head_result.outside, result_if.outside);
                end
                if (result_if.height !== head_result.height) begin
                    n_errors++;
                    $display("%0t ns: height mismatch, expected %0d actual %0d",
                             $time, head_result.height, result_if.height);
                end
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_ORIGIN_X;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.opcode  = OP_WRITE;
        item_if.x_pos   = '0;
        item_if.z_pos   = '0;
        item_if.column  = '0;
        item_if.row     = '0;
        item_if.sample  = '0;
        result_if.ready = 1'b0;
        org_x           = '0;
        org_z           = '0;
        half_extent     = HALF_SIZE_RST;
        inv_cell_w      = INV_CELL_RST;
        src_idle_en     = 1'b1;
        snk_idle_en     = 1'b1;
        hold_off_req    = 0;
        n_errors        = 0;
        n_items         = 0;
        n_writes        = 0;
        n_checked       = 0;
        n_outside       = 0;
        n_cfg           = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_mapping();
        test_extreme_samples();
        test_config_extremes();
        test_random_mix();
        test_backpressure();
        test_streaming();

        @(negedge i_clk);
        item_if.valid <= 1'b0;
        for (int w = 0; w < 5000 && pending_heights.size() != 0; w++) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
        if (pending_heights.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d query results never arrived, expected 0 pending actual %0d",
                     $time, pending_heights.size(), pending_heights.size());
        end
        $display("Run: %0d items, %0d sample writes, %0d register writes.",
                 n_items, n_writes, n_cfg);
        $display("Checked %0d query results, %0d of them off the grid; %0d errors.",
                 n_checked, n_outside, n_errors);
        if (n_errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
